[hdl/rbe_pkg.sv]
// Shared types, codes and the RECTANGLE round function.
package rbe_pkg;

  localparam int BLOCK_W = 64;
  localparam int ROW_W   = 16;
  localparam int IDX_W   = 6;

  localparam logic OP_KEY = 1'b0;
  localparam logic OP_ENC = 1'b1;

  typedef struct packed {
    logic                 encrypt;
    logic [IDX_W-1:0]     idx;
    logic [BLOCK_W-1:0]   data;
  } rbe_cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } rbe_state_t;

  // SubColumn on all sixteen columns, then ShiftRow.
  function automatic logic [BLOCK_W-1:0] round_fn(input logic [BLOCK_W-1:0] blk);
    logic [ROW_W-1:0] r0, r1, r2, r3, a, b;
    r0 = blk[15:0];
    r1 = blk[31:16];
    r2 = blk[47:32];
    r3 = blk[63:48];
    a  = r2;
    r2 = r2 ^ r1;
    r1 = ~r1;
    b  = r0;
    r0 = r0 & r1;
    r1 = r1 | r3;
    r1 = r1 ^ b;
    r3 = r3 ^ a;
    r0 = r0 ^ r3;
    r3 = r3 & r1;
    r3 = r3 ^ r2;
    r2 = r2 | r0;
    r2 = r2 ^ r1;
    r1 = r1 ^ a;
    r1 = {r1[14:0], r1[15]};
    r2 = {r2[3:0], r2[15:4]};
    r3 = {r3[2:0], r3[15:3]};
    return {r3, r2, r1, r0};
  endfunction

endpackage

[hdl/rbe_ram.sv]
// Generic simple dual-port RAM with registered read data.
module rbe_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 26
) (
  input  logic                     clk,
  input  logic                     wen,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/rbe_front.sv]
// Input stage: classifies items, drops out-of-range key writes, and queues commands.
module rbe_front
  import rbe_pkg::*;
#(
  parameter int ROUNDS = 25
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           opcode,
  input  logic [4:0]     key_index,
  input  logic [63:0]    key_value,
  input  logic [63:0]    plaintext,
  output logic           cmd_valid,
  output rbe_cmd_t       cmd,
  input  logic           cmd_pop
);

  rbe_cmd_t   slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       in_range;
  logic       push;
  rbe_cmd_t   new_cmd;

  assign in_range = 32'(key_index) <= 32'(ROUNDS);
  assign in_ready = (count != 2'd2);
  // A key write aimed beyond the store is taken and then discarded.
  assign push     = in_valid && in_ready && ((opcode == OP_ENC) || in_range);

  always_comb begin
    new_cmd.encrypt = (opcode == OP_ENC);
    new_cmd.idx     = IDX_W'(key_index);
    new_cmd.data    = (opcode == OP_ENC) ? plaintext : key_value;
  end

  assign cmd_valid = (count != 2'd0);
  assign cmd       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= new_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (cmd_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !cmd_pop) begin
        count <= count + 2'd1;
      end else if (!push && cmd_pop) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

[hdl/rbe_core.sv]
// Execution stage: performs key writes and runs the rounds, one per cycle.
module rbe_core
  import rbe_pkg::*;
#(
  parameter int ROUNDS = 25
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  input  rbe_cmd_t       cmd,
  output logic           cmd_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [63:0]    ciphertext
);

  localparam int DEPTH = ROUNDS + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [AW-1:0] LAST = AW'(ROUNDS);

  rbe_state_t          state, state_next;
  logic [AW-1:0]       rnd;
  logic [BLOCK_W-1:0]  blk;
  logic [BLOCK_W-1:0]  rkey;
  logic [AW-1:0]       raddr;
  logic                wen;
  logic                slot_free;
  logic                last_rnd;
  logic                finish;
  logic                can_pop;
  logic                start;

  assign slot_free = !out_valid || out_ready;
  assign last_rnd  = (rnd == LAST);
  assign finish    = (state == ST_RUN) && last_rnd && slot_free;

  // Output decode.
  always_comb begin
    can_pop = (state == ST_IDLE) || finish;
    cmd_pop = can_pop && cmd_valid;
    start   = cmd_pop && cmd.encrypt;
    wen     = cmd_pop && !cmd.encrypt;
    if (start) begin
      raddr = '0;
    end else if ((state == ST_RUN) && !last_rnd) begin
      raddr = rnd + AW'(1);
    end else begin
      // Hold the read on the current key while the result slot is full.
      raddr = rnd;
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (finish) begin
          state_next = start ? ST_RUN : ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  rbe_ram #(
    .WIDTH(BLOCK_W),
    .DEPTH(DEPTH)
  ) u_key_ram (
    .clk  (clk),
    .wen  (wen),
    .waddr(AW'(cmd.idx)),
    .wdata(cmd.data),
    .raddr(raddr),
    .rdata(rkey)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rnd       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (start) begin
        rnd <= '0;
      end else if ((state == ST_RUN) && !last_rnd) begin
        rnd <= rnd + AW'(1);
      end
      if (finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      blk <= cmd.data;
    end else if ((state == ST_RUN) && !last_rnd) begin
      blk <= round_fn(blk ^ rkey);
    end
    if (finish) begin
      ciphertext <= blk ^ rkey;
    end
  end

endmodule

[hdl/rectangle_block_encrypt.sv]
// RECTANGLE 64-bit block encryption with a stored set of round keys.
//
// Both channels use valid/ready; a beat moves when valid and ready are high.
// An input beat with opcode 0 writes key_value into round key slot key_index
// (a slot beyond ROUNDS is ignored); opcode 1 encrypts plaintext and yields
// one ciphertext beat. Beats enter a two-entry command queue, so the input
// keeps accepting while a result waits on the output.
// Key writes and encryptions are executed strictly in arrival order, so an
// encryption always sees the keys written before it.
// An encryption runs one round per cycle on a single round unit, reading one
// key per cycle from the key RAM, and blocks run back to back. An accepted
// block passes through the command queue, the rounds and the output register.
// A key write is executed when the execution stage takes it from the queue.
// If the receiver stalls, the finished block holds in the output register
// and the next encryption waits at its final round; the queue then fills and
// in_ready drops. Reset empties the queue and the output; key slots are not
// cleared and must be written before use.
module rectangle_block_encrypt
  import rbe_pkg::*;
#(
  parameter int ROUNDS = 25
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        opcode,
  input  logic [4:0]  key_index,
  input  logic [63:0] key_value,
  input  logic [63:0] plaintext,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] ciphertext
);

  logic     cmd_valid;
  logic     cmd_pop;
  rbe_cmd_t cmd;

  rbe_front #(
    .ROUNDS(ROUNDS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .opcode   (opcode),
    .key_index(key_index),
    .key_value(key_value),
    .plaintext(plaintext),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_pop  (cmd_pop)
  );

  rbe_core #(
    .ROUNDS(ROUNDS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ciphertext(ciphertext)
  );

endmodule
